// ===== design/assert_macros.svh =====
// assertion macros used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// implication checked on the clock after the condition
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/skht_pkg.sv =====
// package: shared types and codes for the string key hash table
package skht_pkg;

   // result status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_TOO_LONG = 3'd3;
   localparam logic [2:0] ST_READ     = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   // input function codes
   localparam logic FN_INSERT = 1'b0;
   localparam logic FN_READ   = 1'b1;

   // hash multiplier
   localparam int unsigned HASH_MULT = 33;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ_WAIT,
      S_READ_DONE,
      S_PROBE_RD,
      S_PROBE_WAIT,
      S_PROBE_EVAL,
      S_CMP_RD,
      S_CMP_WAIT,
      S_CMP_EVAL,
      S_WRITE,
      S_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic take_char;   // append character and hash
      logic clear_key;   // reset incoming key
      logic read_slot;   // start a slot read
      logic probe_start; // load probe position from hash
      logic probe_next;  // step probe position
      logic cmp_start;   // reset compare index
      logic cmp_read;    // read stored character
      logic cmp_next;    // step compare index
      logic write_char;  // copy one character into the store
      logic write_meta;  // mark slot used with length and handle
      logic rsp_fire;    // drive result
      logic [2:0] rsp_status;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic overlong;
      logic key_empty;
      logic slot_used;
      logic len_match;
      logic char_match;
      logic cmp_done;
      logic probe_wrapped;
      logic copy_done;
   } sts_type;

endpackage

// ===== design/string_key_hash_table_insert_top.sv =====
// top level: string key hash table with linear probing
// channel   direction  handshake
// req_*     in         start && !busy accepts one word
// rsp_*     out        rsp_valid marks one-cycle word, no stall
// intermediate character taken while idle; read through a wait state; insert final word
// probes slot by slot (read, wait, evaluate), compares character by character and
// copies character by character, set by the single registered key memory port
// busy holds off the sender while a word is worked on; the receiver cannot stall
// reset clears slot flags and the incoming key at once, no clearing pass
module string_key_hash_table_insert_top #(
   parameter int TABLE_SLOTS = 64,
   parameter int KEY_CHARS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [7:0]  req_key_char,
   input  logic        req_key_last,
   input  logic [31:0] req_handle,
   input  logic [5:0]  req_slot,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_occupied,
   output logic [31:0] rsp_handle_out
);
   skht_pkg::ctl_type ctl;
   skht_pkg::sts_type sts;

   skht_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_start(start), .req_func(req_func),
      .req_key_last(req_key_last), .req_busy(busy), .ctl(ctl), .sts(sts)
   );

   skht_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_CHARS(KEY_CHARS)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .req_key_char(req_key_char), .req_handle(req_handle), .req_slot(req_slot),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index), .rsp_occupied(rsp_occupied),
      .rsp_handle_out(rsp_handle_out)
   );

endmodule

// ===== design/skht_datapath.sv =====
// datapath: hash, incoming key, slot stores and probe counters
module skht_datapath #(
   parameter int TABLE_SLOTS = 64,
   parameter int KEY_CHARS   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  skht_pkg::ctl_type ctl,
   output skht_pkg::sts_type sts,
   input  logic [7:0]       req_key_char,
   input  logic [31:0]      req_handle,
   input  logic [5:0]       req_slot,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [5:0]       rsp_slot_index,
   output logic             rsp_occupied,
   output logic [31:0]      rsp_handle_out
);
   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int KW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
   localparam int LW = $clog2(KEY_CHARS + 1);
   localparam int SLW = $clog2(TABLE_SLOTS + 1);
   localparam int OW = (SW < 6) ? SW : 6;

   // key store memory, one row of 2**KW characters per slot
   logic [7:0]  key_mem [TABLE_SLOTS*(2**KW)];
   logic [31:0] handle_mem [TABLE_SLOTS];
   logic [LW-1:0] len_mem [TABLE_SLOTS];
   logic [7:0]  inc_mem [KEY_CHARS];

   logic [TABLE_SLOTS-1:0] used_ff;
   logic [LW-1:0] inc_len_ff;
   logic [31:0]   hash_ff;
   logic          overlong_ff;
   logic [SW-1:0] pos_ff;
   logic [SLW-1:0] count_ff;
   logic [KW-1:0] idx_ff;
   logic [LW-1:0] cnt_ff;
   logic [7:0]    key_rd_ff, inc_rd_ff;
   logic [31:0]   handle_rd_ff;
   logic [LW-1:0] len_rd_ff;
   logic          used_rd_ff;
   logic [31:0]   req_handle_ff;
   logic [5:0]    rd_slot_ff;
   logic          rd_range_ff;
   logic [31:0]   hash_in;

   assign hash_in = hash_ff * 32'(skht_pkg::HASH_MULT) + 32'(req_key_char);

   // incoming key assembly
   always_ff @(posedge clock) begin
      if (reset || ctl.clear_key) begin
         inc_len_ff  <= '0;
         hash_ff     <= '0;
         overlong_ff <= 1'b0;
      end else if (ctl.take_char && req_key_char != 8'd0) begin
         hash_ff <= hash_in;
         if (inc_len_ff < LW'(KEY_CHARS - 1)) begin
            inc_len_ff <= inc_len_ff + LW'(1);
         end else begin
            overlong_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take_char && req_key_char != 8'd0 && inc_len_ff < LW'(KEY_CHARS - 1)) begin
         inc_mem[inc_len_ff[KW-1:0]] <= req_key_char;
      end
      if (ctl.take_char) begin
         req_handle_ff <= req_handle;
      end
   end

   // probe position and counters
   always_ff @(posedge clock) begin
      if (ctl.probe_start) begin
         pos_ff   <= SW'(hash_ff % TABLE_SLOTS);
         count_ff <= '0;
      end else if (ctl.probe_next) begin
         pos_ff   <= (pos_ff == SW'(TABLE_SLOTS - 1)) ? '0 : pos_ff + SW'(1);
         count_ff <= count_ff + SLW'(1);
      end else if (ctl.read_slot) begin
         pos_ff <= SW'(req_slot);
      end
      if (ctl.read_slot) begin
         rd_slot_ff  <= req_slot;
         rd_range_ff <= (32'(req_slot) < TABLE_SLOTS);
      end
      if (ctl.cmp_start) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else if (ctl.cmp_next || ctl.write_char) begin
         idx_ff <= idx_ff + KW'(1);
         cnt_ff <= cnt_ff + LW'(1);
      end
   end

   // slot metadata and key memory reads
   always_ff @(posedge clock) begin
      handle_rd_ff <= handle_mem[pos_ff];
      len_rd_ff    <= len_mem[pos_ff];
      key_rd_ff    <= key_mem[{pos_ff, idx_ff}];
      inc_rd_ff    <= inc_mem[idx_ff];
      used_rd_ff   <= used_ff[pos_ff];
   end

   // store writes
   always_ff @(posedge clock) begin
      if (ctl.write_char) begin
         key_mem[{pos_ff, idx_ff}] <= inc_rd_ff;
      end
      if (ctl.write_meta) begin
         handle_mem[pos_ff] <= req_handle_ff;
         len_mem[pos_ff]    <= inc_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (ctl.write_meta) begin
         used_ff[pos_ff] <= 1'b1;
      end
   end

   assign sts.overlong      = overlong_ff;
   assign sts.key_empty     = (inc_len_ff == '0);
   assign sts.slot_used     = used_rd_ff;
   assign sts.len_match     = (len_rd_ff == inc_len_ff);
   assign sts.char_match    = (key_rd_ff == inc_rd_ff);
   assign sts.cmp_done      = (cnt_ff == inc_len_ff);
   assign sts.probe_wrapped = (count_ff == SLW'(TABLE_SLOTS - 1));
   assign sts.copy_done     = (cnt_ff == inc_len_ff);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctl.rsp_fire;
      end
      if (ctl.rsp_fire) begin
         rsp_status     <= ctl.rsp_status;
         rsp_occupied   <= 1'b0;
         rsp_slot_index <= '0;
         rsp_handle_out <= '0;
         unique case (ctl.rsp_status)
            skht_pkg::ST_READ: begin
               rsp_slot_index <= rd_slot_ff;
               if (rd_range_ff && used_rd_ff) begin
                  rsp_occupied   <= 1'b1;
                  rsp_handle_out <= handle_rd_ff;
               end
            end
            skht_pkg::ST_INSERTED: begin
               rsp_slot_index <= 6'(pos_ff[OW-1:0]);
               rsp_handle_out <= req_handle_ff;
            end
            skht_pkg::ST_PRESENT: begin
               rsp_slot_index <= 6'(pos_ff[OW-1:0]);
               rsp_handle_out <= handle_rd_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== design/skht_ctrl.sv =====
// controller: sequences character intake, probing, compare and write
`include "assert_macros.svh"
module skht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   input  logic              req_func,
   input  logic              req_key_last,
   output logic              req_busy,
   output skht_pkg::ctl_type ctl,
   input  skht_pkg::sts_type sts
);
   skht_pkg::state_type state_ff, state_in;
   logic wr_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skht_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      req_busy = 1'b1;
      unique case (state_ff)
         skht_pkg::S_IDLE: begin
            req_busy = 1'b0;
            if (req_start) begin
               if (req_func == skht_pkg::FN_READ) begin
                  ctl.read_slot = 1'b1;
                  state_in      = skht_pkg::S_READ_WAIT;
               end else begin
                  ctl.take_char = 1'b1;
                  if (req_key_last) begin
                     state_in = skht_pkg::S_DONE;
                  end
               end
            end
         end
         skht_pkg::S_READ_WAIT: state_in = skht_pkg::S_READ_DONE;
         skht_pkg::S_READ_DONE: begin
            ctl.rsp_fire   = 1'b1;
            ctl.rsp_status = skht_pkg::ST_READ;
            state_in       = skht_pkg::S_IDLE;
         end
         skht_pkg::S_DONE: begin
            if (sts.overlong) begin
               ctl.rsp_fire = 1'b1; ctl.rsp_status = skht_pkg::ST_TOO_LONG;
               ctl.clear_key = 1'b1; state_in = skht_pkg::S_IDLE;
            end else if (sts.key_empty) begin
               ctl.rsp_fire = 1'b1; ctl.rsp_status = skht_pkg::ST_EMPTY;
               ctl.clear_key = 1'b1; state_in = skht_pkg::S_IDLE;
            end else begin
               ctl.probe_start = 1'b1;
               state_in = skht_pkg::S_PROBE_RD;
            end
         end
         skht_pkg::S_PROBE_RD: begin
            ctl.cmp_start = 1'b1;
            state_in = skht_pkg::S_PROBE_WAIT;
         end
         skht_pkg::S_PROBE_WAIT: state_in = skht_pkg::S_PROBE_EVAL;
         skht_pkg::S_PROBE_EVAL: begin
            if (!sts.slot_used) begin
               state_in = skht_pkg::S_WRITE;
            end else if (sts.len_match) begin
               state_in = skht_pkg::S_CMP_EVAL;
            end else if (sts.probe_wrapped) begin
               ctl.rsp_fire = 1'b1; ctl.rsp_status = skht_pkg::ST_FULL;
               ctl.clear_key = 1'b1; state_in = skht_pkg::S_IDLE;
            end else begin
               ctl.probe_next = 1'b1;
               state_in = skht_pkg::S_PROBE_RD;
            end
         end
         skht_pkg::S_CMP_EVAL: begin
            if (sts.cmp_done) begin
               ctl.rsp_fire = 1'b1; ctl.rsp_status = skht_pkg::ST_PRESENT;
               ctl.clear_key = 1'b1; state_in = skht_pkg::S_IDLE;
            end else if (!sts.char_match) begin
               if (sts.probe_wrapped) begin
                  ctl.rsp_fire = 1'b1; ctl.rsp_status = skht_pkg::ST_FULL;
                  ctl.clear_key = 1'b1; state_in = skht_pkg::S_IDLE;
               end else begin
                  ctl.probe_next = 1'b1;
                  state_in = skht_pkg::S_PROBE_RD;
               end
            end else begin
               ctl.cmp_next = 1'b1;
               state_in = skht_pkg::S_CMP_RD;
            end
         end
         skht_pkg::S_CMP_RD: state_in = skht_pkg::S_CMP_WAIT;
         skht_pkg::S_CMP_WAIT: state_in = skht_pkg::S_CMP_EVAL;
         skht_pkg::S_WRITE: begin
            // incoming char read is registered: each char is written from the compare wait state
            if (sts.copy_done) begin
               ctl.write_meta = 1'b1;
               ctl.rsp_fire = 1'b1; ctl.rsp_status = skht_pkg::ST_INSERTED;
               ctl.clear_key = 1'b1; state_in = skht_pkg::S_IDLE;
            end else begin
               state_in = skht_pkg::S_CMP_WAIT;
            end
         end
         default: state_in = skht_pkg::S_IDLE;
      endcase
      // copy path reuses the compare wait state
      if (state_ff == skht_pkg::S_CMP_WAIT && wr_mode_ff) begin
         ctl.write_char = 1'b1;
         state_in = skht_pkg::S_WRITE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || state_ff == skht_pkg::S_IDLE) begin
         wr_mode_ff <= 1'b0;
      end else if (state_in == skht_pkg::S_WRITE) begin
         wr_mode_ff <= 1'b1;
      end
   end

   `ASSERT_IMPLIES(a_busy_idle, clock, reset, state_ff == skht_pkg::S_IDLE, !req_busy,
      "busy while idle")
   `ASSERT_IMPLIES(a_one_cmd, clock, reset, 1'b1,
      $onehot0({ctl.probe_start, ctl.probe_next, ctl.read_slot}), "probe commands collide")
   `ASSERT_NEXT(a_fire_idle, clock, reset, ctl.rsp_fire, state_ff == skht_pkg::S_IDLE,
      "result not followed by idle")

endmodule

// ===== verif/tb_string_key_hash_table_insert_top.sv =====
// testbench: string key hash table insert, predictor-checked with directed and random words
module tb_string_key_hash_table_insert_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 64;
   localparam int CHARS      = 32;
   localparam int WORD_COUNT = 1100;
   localparam int CYCLE_CAP  = 20000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot_index;
      logic        occupied;
      logic [31:0] handle_out;
   } answer_type;

   typedef struct {
      logic        func;
      logic [7:0]  key_char;
      logic        key_last;
      logic [31:0] handle;
      logic [5:0]  slot;
      bit          typed;
      answer_type  answer;
   } row_type;

   typedef struct {
      logic [7:0] text[40];
      int         len;
   } key_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = skht_pkg::FN_INSERT;
   logic [7:0]  req_key_char = '0;
   logic        req_key_last = 1'b0;
   logic [31:0] req_handle = '0;
   logic [5:0]  req_slot = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_slot_index;
   logic        rsp_occupied;
   logic [31:0] rsp_handle_out;

   // table mirror
   logic [7:0]  tbl_text[SLOTS][CHARS];
   int          tbl_len[SLOTS];
   bit          tbl_used[SLOTS];
   logic [31:0] tbl_handle[SLOTS];
   logic [7:0]  new_text[CHARS];
   int          new_len;
   logic [31:0] key_hash;
   bit          key_overlong;

   answer_type  pending[$];
   key_type     key_pool[$];
   int          failures = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int unsigned cycles = 0;

   string_key_hash_table_insert_top dut (.*);

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void clear_new_key();
      for (int i = 0; i < CHARS; i++) new_text[i] = '0;
      new_len = 0;
      key_hash = '0;
      key_overlong = 0;
   endfunction

   // table behavior for one accepted word
   function automatic bit table_step(input logic func, input logic [7:0] c,
                                     input logic last, input logic [31:0] h,
                                     input logic [5:0] s, output answer_type a);
      int pos;
      bit same;
      a = '0;
      if (func == skht_pkg::FN_READ) begin
         a.status = skht_pkg::ST_READ;
         a.slot_index = s;
         if (tbl_used[s]) begin
            a.occupied = 1'b1;
            a.handle_out = tbl_handle[s];
         end
         return 1;
      end
      if (c != 0) begin
         key_hash = key_hash * skht_pkg::HASH_MULT + c;
         if (new_len < CHARS - 1) begin
            new_text[new_len] = c;
            new_len++;
         end else key_overlong = 1;
      end
      if (!last) return 0;
      if (key_overlong) a.status = skht_pkg::ST_TOO_LONG;
      else if (new_len == 0) a.status = skht_pkg::ST_EMPTY;
      else begin
         a.status = skht_pkg::ST_FULL;
         pos = int'(key_hash % SLOTS);
         for (int n = 0; n < SLOTS; n++) begin
            if (!tbl_used[pos]) begin
               for (int i = 0; i < CHARS; i++)
                  tbl_text[pos][i] = (i < new_len) ? new_text[i] : 8'h0;
               tbl_len[pos] = new_len;
               tbl_handle[pos] = h;
               tbl_used[pos] = 1;
               a.status = skht_pkg::ST_INSERTED;
               a.slot_index = 6'(pos);
               a.handle_out = h;
               break;
            end
            same = (tbl_len[pos] == new_len);
            for (int i = 0; i < new_len; i++)
               if (tbl_text[pos][i] != new_text[i]) same = 0;
            if (same) begin
               a.status = skht_pkg::ST_PRESENT;
               a.slot_index = 6'(pos);
               a.handle_out = tbl_handle[pos];
               break;
            end
            pos = (pos + 1) % SLOTS;
         end
      end
      clear_new_key();
      return 1;
   endfunction

   // drive one word, with bursty gaps, and record its expected answer when it has one
   task automatic send_word(input logic func, input logic [7:0] c, input logic last,
                            input logic [31:0] h, input logic [5:0] s,
                            input bit typed = 0, input answer_type typed_answer = '0);
      answer_type a;
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start = 1'b1;
      req_func = func;
      req_key_char = c;
      req_key_last = last;
      req_handle = h;
      req_slot = s;
      do @(posedge clock); while (busy);
      words_sent++;
      if (table_step(func, c, last, h, s, a)) pending.push_back(typed ? typed_answer : a);
      if (burst_left == 0) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic send_key(input key_type k, input logic [31:0] h);
      logic [7:0] c;
      for (int i = 0; i < k.len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_word(skht_pkg::FN_READ, 8'($urandom), 1'b0, $urandom,
                      6'($urandom_range(0, SLOTS - 1)));
         // stray zero characters are dropped by the block
         if ($urandom_range(0, 29) == 0)
            send_word(skht_pkg::FN_INSERT, 8'h0, 1'b0, $urandom, 6'($urandom));
         c = k.text[i];
         send_word(skht_pkg::FN_INSERT, c, (i == k.len - 1), h, 6'($urandom));
      end
      // close an empty key, and occasionally follow a key, with a last zero character
      if (k.len == 0 || $urandom_range(0, 19) == 0)
         send_word(skht_pkg::FN_INSERT, 8'h0, 1'b1, h, 6'($urandom));
   endtask

   // result checker
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            $display("%0t: unexpected word status=%0d slot=%0d occ=%0b handle=%h", $realtime,
                     rsp_status, rsp_slot_index, rsp_occupied, rsp_handle_out);
            failures++;
         end else begin
            want = pending.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime, want.status, rsp_status);
               failures++;
            end
            if (rsp_slot_index !== want.slot_index) begin
               $display("%0t: slot_index expected %0d actual %0d", $realtime, want.slot_index,
                        rsp_slot_index);
               failures++;
            end
            if (rsp_occupied !== want.occupied) begin
               $display("%0t: occupied expected %0b actual %0b", $realtime, want.occupied,
                        rsp_occupied);
               failures++;
            end
            if (rsp_handle_out !== want.handle_out) begin
               $display("%0t: handle_out expected %h actual %h", $realtime, want.handle_out,
                        rsp_handle_out);
               failures++;
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      key_type k;
      int pick;
      for (int s = 0; s < SLOTS; s++) begin
         tbl_used[s] = 0;
         tbl_len[s] = 0;
      end
      clear_new_key();

      // directed words: reads after reset, empty key, extremes, duplicate, too long
      rows.push_back('{skht_pkg::FN_READ, 8'h00, 1'b0, 32'h0, 6'd0, 1,
                       '{skht_pkg::ST_READ, 6'd0, 1'b0, 32'h0}});
      rows.push_back('{skht_pkg::FN_READ, 8'hFF, 1'b1, 32'hFFFFFFFF, 6'd63, 1,
                       '{skht_pkg::ST_READ, 6'd63, 1'b0, 32'h0}});
      rows.push_back('{skht_pkg::FN_INSERT, 8'h00, 1'b1, 32'h1234, 6'd0, 1,
                       '{skht_pkg::ST_EMPTY, 6'd0, 1'b0, 32'h0}});
      rows.push_back('{skht_pkg::FN_INSERT, 8'hFF, 1'b1, 32'hFFFFFFFF, 6'd63, 1,
                       '{skht_pkg::ST_INSERTED, 6'd63, 1'b0, 32'hFFFFFFFF}});
      rows.push_back('{skht_pkg::FN_INSERT, 8'hFF, 1'b1, 32'h0, 6'd0, 1,
                       '{skht_pkg::ST_PRESENT, 6'd63, 1'b0, 32'hFFFFFFFF}});
      rows.push_back('{skht_pkg::FN_READ, 8'h00, 1'b0, 32'h0, 6'd63, 1,
                       '{skht_pkg::ST_READ, 6'd63, 1'b1, 32'hFFFFFFFF}});
      rows.push_back('{skht_pkg::FN_INSERT, 8'h01, 1'b0, 32'h0,        6'd0,  0, '0});
      rows.push_back('{skht_pkg::FN_READ,   8'h00, 1'b0, 32'h0,        6'd1,  0, '0});
      rows.push_back('{skht_pkg::FN_INSERT, 8'h00, 1'b0, 32'h0,        6'd0,  0, '0});
      rows.push_back('{skht_pkg::FN_INSERT, 8'h80, 1'b1, 32'h00000000, 6'd0,  0, '0});
      rows.push_back('{skht_pkg::FN_INSERT, 8'h01, 1'b0, 32'h0,        6'd0,  0, '0});
      rows.push_back('{skht_pkg::FN_INSERT, 8'h00, 1'b1, 32'hA5A5A5A5, 6'd0,  0, '0});
      for (int i = 0; i < 32; i++)
         rows.push_back('{skht_pkg::FN_INSERT, 8'h41 + i[7:0], 1'b0, 32'h0, 6'd0, 0, '0});
      rows.push_back('{skht_pkg::FN_INSERT, 8'h7F, 1'b1, 32'h5, 6'd0, 1,
                       '{skht_pkg::ST_TOO_LONG, 6'd0, 1'b0, 32'h0}});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_word(rows[i].func, rows[i].key_char, rows[i].key_last, rows[i].handle,
                   rows[i].slot, rows[i].typed, rows[i].answer);

      // hold off until the directed words have all answered
      @(negedge clock);
      start = 1'b0;
      burst_left = 0;
      while (pending.size() != 0) @(posedge clock);

      // random keys: fresh keys fill the table, reused ones hit the duplicate path
      while (words_sent < WORD_COUNT) begin
         if (key_pool.size() > 0 && $urandom_range(0, 9) < 4) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) k.len = $urandom_range(1, 6);
            else if (pick < 90) k.len = $urandom_range(25, 31);
            else if (pick < 95) k.len = $urandom_range(32, 34);
            else k.len = 0;
            for (int i = 0; i < k.len; i++) k.text[i] = 8'($urandom_range(1, 255));
            if (k.len > 0 && k.len < CHARS) key_pool.push_back(k);
         end
         send_key(k, $urandom);
         if ($urandom_range(0, 4) == 0)
            send_word(skht_pkg::FN_READ, 8'($urandom), 1'($urandom), $urandom,
                      6'($urandom_range(0, SLOTS - 1)));
      end

      @(negedge clock);
      start = 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/skht_pkg.sv
design/skht_datapath.sv
design/skht_ctrl.sv
design/string_key_hash_table_insert_top.sv
verif/tb_string_key_hash_table_insert_top.sv
